// File: rtl/image_plane_resampler_macros.svh
// Assertion macros for the image plane resampler.
`ifndef IMAGE_PLANE_RESAMPLER_MACROS_SVH
`define IMAGE_PLANE_RESAMPLER_MACROS_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define IPR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("image_plane_resampler: assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define IPR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("image_plane_resampler: assertion failed");
`else
`define IPR_ASSERT_NOW(lbl, ante, cons)
`define IPR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/ipr_pkg.sv
// Shared types and constants for the image plane resampler.
`default_nettype none
package ipr_pkg;
    localparam int PIX_W   = 16;
    localparam int FRAC_W  = 16;
    localparam int STEP_W  = 24;
    localparam int COORD_W = 12;
    localparam int SIZE_W  = 9;

    // Resampling modes.
    localparam logic [1:0] MODE_CUSTOM  = 2'd0;
    localparam logic [1:0] MODE_ALIGN   = 2'd1;
    localparam logic [1:0] MODE_HALF    = 2'd2;
    localparam logic [1:0] MODE_NEAREST = 2'd3;

    // Request function codes.
    localparam logic FUNC_STORE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_WIDTH  = 3'd1;
    localparam logic [2:0] REG_HEIGHT = 3'd2;
    localparam logic [2:0] REG_STEP_X = 3'd3;
    localparam logic [2:0] REG_STEP_Y = 3'd4;

    typedef struct packed {
        logic [1:0]          mode;
        logic [SIZE_W-1:0]   in_width;
        logic [SIZE_W-1:0]   in_height;
        logic [STEP_W-1:0]   step_x;
        logic [STEP_W-1:0]   step_y;
    } t_cfg;

    // Classified request passed from the front end to the back end.
    // vld bits: 0 start column, 1 end column, 2 start row, 3 end row.
    typedef struct packed {
        logic                req;
        logic [COORD_W-1:0]  xs;
        logic [COORD_W-1:0]  xe;
        logic [COORD_W-1:0]  ys;
        logic [COORD_W-1:0]  ye;
        logic [3:0]          vld;
        logic [FRAC_W-1:0]   fx;
        logic [FRAC_W-1:0]   fy;
        logic [PIX_W-1:0]    data;
    } t_item;
endpackage
`default_nettype wire

// File: rtl/image_plane_resampler.sv
// Image plane resampler: one item per cycle while the result side does not stall; a read
// passes the front register, the queue, the store read, product and result registers.
// Throughput is one item per clock unless stalled, set by the one read port per store copy.
// Synchronous active-low reset restores the register defaults and empties the pipeline.
// The frame store itself is not cleared; entries hold nothing until written.
`include "image_plane_resampler_macros.svh"
`default_nettype none
module image_plane_resampler import ipr_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_addr,
    input  wire logic [STEP_W-1:0]  i_cfg_wdata,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_func,
    input  wire logic [COORD_W-1:0] i_coord_x,
    input  wire logic [COORD_W-1:0] i_coord_y,
    input  wire logic [PIX_W-1:0]   i_pixel_in,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [PIX_W-1:0]        o_pixel_out
);
    t_cfg  r_cfg;
    logic  w_f_valid, w_q_ready, w_q_valid, w_pop;
    t_item w_f_item, w_q_item;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode      <= MODE_ALIGN;
            r_cfg.in_width  <= 9'd256;
            r_cfg.in_height <= 9'd256;
            r_cfg.step_x    <= 24'd65536;
            r_cfg.step_y    <= 24'd65536;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_MODE:   r_cfg.mode      <= i_cfg_wdata[1:0];
                REG_WIDTH:  r_cfg.in_width  <= i_cfg_wdata[SIZE_W-1:0];
                REG_HEIGHT: r_cfg.in_height <= i_cfg_wdata[SIZE_W-1:0];
                REG_STEP_X: r_cfg.step_x    <= i_cfg_wdata;
                REG_STEP_Y: r_cfg.step_y    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    ipr_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_func     (i_func),
        .i_coord_x  (i_coord_x),
        .i_coord_y  (i_coord_y),
        .i_pixel_in (i_pixel_in),
        .o_valid    (w_f_valid),
        .o_item     (w_f_item),
        .i_q_ready  (w_q_ready)
    );

    ipr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid),
        .i_item  (w_f_item),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    ipr_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_item      (w_q_item),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pixel_out (o_pixel_out)
    );

    // The front end keeps its request while the queue is full.
    `IPR_ASSERT_NEXT(a_front_holds, w_f_valid && !w_q_ready, w_f_valid)
    // The back end only pops a queue that holds a request.
    `IPR_ASSERT_NOW(a_pop_nonempty, w_pop, w_q_valid)
    // A full queue behind a held request blocks the input.
    `IPR_ASSERT_NOW(a_ready_stall, w_f_valid && !w_q_ready, !o_ready)
endmodule
`default_nettype wire

// File: rtl/ipr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ipr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, held while not enabled.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// File: rtl/ipr_fifo.sv
// Short request queue between the front end and the back end.
`default_nettype none
module ipr_fifo import ipr_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_ready,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_item      o_item
);
    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    t_item           r_mem [DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;

    assign o_ready = (r_cnt != (PW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push && o_ready) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && o_ready) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop && o_valid) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(i_push && o_ready) - (PW+1)'(i_pop && o_valid);
        end
    end
endmodule
`default_nettype wire

// File: rtl/ipr_front.sv
// Front end: accepts requests and works out neighbour positions and weights.
`default_nettype none
module ipr_front import ipr_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_func,
    input  wire logic [COORD_W-1:0] i_coord_x,
    input  wire logic [COORD_W-1:0] i_coord_y,
    input  wire logic [PIX_W-1:0]   i_pixel_in,
    output logic                    o_valid,
    output t_item                   o_item,
    input  wire logic               i_q_ready
);
    typedef struct packed {
        logic [COORD_W-1:0] s;
        logic [COORD_W-1:0] e;
        logic               vs;
        logic               ve;
        logic [FRAC_W-1:0]  f;
    } t_axis;

    // One axis: source position, neighbours and fraction for a coordinate.
    function automatic t_axis f_axis(input logic [COORD_W-1:0] c,
                                     input logic [STEP_W-1:0] st,
                                     input logic [1:0] md,
                                     input logic [21:0] lim);
        logic [12:0] cm;
        logic [36:0] prod;
        logic [36:0] p;
        logic [21:0] sp, ep;
        t_axis       a;
        cm   = (md == MODE_HALF) ? {c, 1'b1} : {1'b0, c};
        prod = {24'b0, cm} * {13'b0, st};
        if (md == MODE_HALF) begin
            p = (prod < 37'd65536) ? 37'd0 : ((prod - 37'd65536) >> 1);
        end else if (md == MODE_NEAREST) begin
            p = prod + 37'd32768;
        end else begin
            p = prod;
        end
        sp = {1'b0, p[36:16]};
        ep = sp + 22'd1;
        if (md == MODE_NEAREST) begin
            ep = sp;
        end else if (md != MODE_CUSTOM && !(ep < lim)) begin
            ep = sp;
        end
        a.vs = (sp < lim);
        a.ve = (ep < lim) && (md != MODE_NEAREST);
        a.s  = a.vs ? sp[COORD_W-1:0] : '0;
        a.e  = a.ve ? ep[COORD_W-1:0] : '0;
        a.f  = (md == MODE_NEAREST) ? '0 : p[15:0];
        return a;
    endfunction

    logic [21:0] w_lim_x, w_lim_y;
    t_axis       w_ax, w_ay;
    t_item       n_item, r_item;
    logic        r_valid;
    logic        w_acc;
    logic        w_in_x, w_in_y;

    assign w_lim_x = (22'(i_cfg.in_width) < 22'(MAX_WIDTH)) ?
                     22'(i_cfg.in_width) : 22'(MAX_WIDTH);
    assign w_lim_y = (22'(i_cfg.in_height) < 22'(MAX_HEIGHT)) ?
                     22'(i_cfg.in_height) : 22'(MAX_HEIGHT);
    assign w_ax    = f_axis(i_coord_x, i_cfg.step_x, i_cfg.mode, w_lim_x);
    assign w_ay    = f_axis(i_coord_y, i_cfg.step_y, i_cfg.mode, w_lim_y);
    assign w_in_x  = (13'(i_coord_x) < 13'(MAX_WIDTH));
    assign w_in_y  = (13'(i_coord_y) < 13'(MAX_HEIGHT));

    assign o_ready = !r_valid || i_q_ready;
    assign w_acc   = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Classify: a store carries its address, a read its neighbours.
    always_comb begin
        n_item      = '0;
        n_item.req  = (i_func == FUNC_READ);
        n_item.data = i_pixel_in;
        if (i_func == FUNC_READ) begin
            n_item.xs  = w_ax.s;
            n_item.xe  = w_ax.e;
            n_item.ys  = w_ay.s;
            n_item.ye  = w_ay.e;
            n_item.vld = {w_ay.ve, w_ay.vs, w_ax.ve, w_ax.vs};
            n_item.fx  = w_ax.f;
            n_item.fy  = w_ay.f;
        end else begin
            n_item.xs  = i_coord_x;
            n_item.ys  = i_coord_y;
            n_item.vld = {3'b000, w_in_x && w_in_y};
        end
    end

    // Output register toward the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_acc) begin
            r_valid <= 1'b1;
        end else if (i_q_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_item <= n_item;
        end
    end
endmodule
`default_nettype wire

// File: rtl/ipr_back.sv
// Back end: frame store access, weighting, rounding and the result register.
`default_nettype none
module ipr_back import ipr_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    input  wire t_item            i_item,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [PIX_W-1:0]      o_pixel_out
);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);

    logic              w_adv, w_we;
    logic [AW-1:0]     w_addr [4];
    logic [PIX_W-1:0]  w_rd [4];
    logic [3:0]        w_nv;
    logic [16:0]       w_gx, w_gy, w_ax, w_ay;
    logic [33:0]       r_w [4];
    logic [3:0]        r_nv;
    logic              r_v2, r_v3, r_ov;
    logic signed [50:0] r_p [4];
    logic signed [50:0] w_acc;
    logic signed [50:0] w_t;
    logic [PIX_W-1:0]  w_sat, r_out;

    // The whole pipeline moves whenever the result register can take a value.
    assign w_adv  = !r_ov || i_ready;
    assign o_pop  = w_adv && i_q_valid;
    assign w_we   = o_pop && !i_item.req && i_item.vld[0];

    // Neighbour addresses: start/start, end/start, start/end, end/end.
    assign w_addr[0] = AW'(i_item.ys[YW-1:0]) * AW'(MAX_WIDTH) + AW'(i_item.xs[XW-1:0]);
    assign w_addr[1] = AW'(i_item.ys[YW-1:0]) * AW'(MAX_WIDTH) + AW'(i_item.xe[XW-1:0]);
    assign w_addr[2] = AW'(i_item.ye[YW-1:0]) * AW'(MAX_WIDTH) + AW'(i_item.xs[XW-1:0]);
    assign w_addr[3] = AW'(i_item.ye[YW-1:0]) * AW'(MAX_WIDTH) + AW'(i_item.xe[XW-1:0]);

    assign w_nv = {i_item.vld[1] & i_item.vld[3], i_item.vld[0] & i_item.vld[3],
                   i_item.vld[1] & i_item.vld[2], i_item.vld[0] & i_item.vld[2]};

    // One frame store copy per neighbour; stores write all copies.
    for (genvar g = 0; g < 4; g++) begin : g_bank
        ipr_ram #(
            .WIDTH (PIX_W),
            .DEPTH (DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_waddr (w_addr[0]),
            .i_wdata (i_item.data),
            .i_re    (w_adv),
            .i_raddr (w_addr[g]),
            .o_rdata (w_rd[g])
        );
    end

    // Bilinear weights, Q2.32.
    assign w_ax = {1'b0, i_item.fx};
    assign w_ay = {1'b0, i_item.fy};
    assign w_gx = 17'd65536 - w_ax;
    assign w_gy = 17'd65536 - w_ay;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_w[0] <= 34'(w_gy) * 34'(w_gx);
            r_w[1] <= 34'(w_gy) * 34'(w_ax);
            r_w[2] <= 34'(w_ay) * 34'(w_gx);
            r_w[3] <= 34'(w_ay) * 34'(w_ax);
            r_nv   <= w_nv;
        end
    end

    // Weighted neighbours; an out-of-range neighbour counts as zero.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 4; i++) begin
                r_p[i] <= $signed({17'b0, r_w[i]}) *
                          $signed({{35{w_rd[i][PIX_W-1]}}, w_rd[i]} & {51{r_nv[i]}});
            end
        end
    end

    // Sum, round half up to Q8.8 and saturate.
    assign w_acc = r_p[0] + r_p[1] + r_p[2] + r_p[3];
    assign w_t   = (w_acc + 51'sd2147483648) >>> 32;
    always_comb begin
        if (w_t > 51'sd32767) begin
            w_sat = 16'h7FFF;
        end else if (w_t < -51'sd32768) begin
            w_sat = 16'h8000;
        end else begin
            w_sat = w_t[PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_sat;
        end
    end

    // Stage valid flags; only reads produce a result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_v2 <= i_q_valid && i_item.req;
            r_v3 <= r_v2;
            r_ov <= r_v3;
        end
    end

    assign o_valid     = r_ov;
    assign o_pixel_out = r_out;
endmodule
`default_nettype wire
